@@ rtl/core/lge_pkg.sv @@
// Shared definitions for the life grid generation engine.
// Field widths, register codes, operation codes and rule constants.
// No dependencies.
package lge_pkg;

  localparam int MAX_WIDTH_DEF  = 64;
  localparam int MAX_HEIGHT_DEF = 64;

  localparam int REG_W     = 7;
  localparam int COL_W     = 6;
  localparam int ROW_W     = 6;
  localparam int IDX_W     = 6;
  localparam int MODE_W    = 2;
  localparam int CFG_IDX_W = 1;

  localparam logic [REG_W-1:0] REG_RESET = 7'd64;

  // neighbor count of one cell never exceeds eight
  localparam int NBR_CNT_W = 4;
  localparam logic [NBR_CNT_W-1:0] BIRTH_CNT   = 4'd3;
  localparam logic [NBR_CNT_W-1:0] SURVIVE_CNT = 4'd2;

  typedef enum logic [MODE_W-1:0] {
    MODE_TOGGLE  = 2'd0,
    MODE_ADVANCE = 2'd1,
    MODE_CLEAR   = 2'd2
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_WIDTH  = 1'b0,
    CFG_GRID_HEIGHT = 1'b1
  } cfg_reg_t;

endpackage

@@ rtl/core/life_grid_generation_engine.sv @@
// Life grid generation engine: bounded B3/S23 grid kept in one row RAM.
// Input channel (in_valid/in_stall) carries mode, col, row. Toggle flips one
// cell and returns that row; clear kills every cell and returns one result;
// advance returns every in-use row in order, last set on the final row and
// stable set there when no cell changed. A toggle outside the grid returns one
// result with applied low. Result channel is out_valid/out_stall with one
// output register; a transfer happens when valid is high and stall is low.
// Sequence with no receiver stall: a toggle, clear or refused toggle passes
// through S_TGL or S_ONE, which loads its result, and then returns to idle.
// An advance passes through S_ADV_LOAD, then S_ADV_CALC loads one row per
// cycle, row 0 first, and returns to idle after the last row, with the single
// RAM read port streaming one row per cycle with a one-row look-ahead.
// One item is worked at a time: in_stall is high from acceptance until the
// item's last result is loaded into the output register. A receiver stall
// holds the output register and freezes the row sequencer in place.
// Reset (rst_n low, synchronous): grid reads as all dead through per-row
// valid flops, so no clearing sweep is needed; width and height return to 64.
// Depends on lge_pkg, lge_ram and lge_row_rule.
module life_grid_generation_engine
  import lge_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [MODE_W-1:0]    in_mode,
  input  logic [COL_W-1:0]     in_col,
  input  logic [ROW_W-1:0]     in_row,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [IDX_W-1:0]     out_row_index,
  output logic [MAX_WIDTH-1:0] out_row_bits,
  output logic                 out_applied,
  output logic                 out_stable,
  output logic                 out_last,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_wdata
);

  localparam int AW    = $clog2(MAX_HEIGHT);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int CMP_W = ((COL_W > WW) ? COL_W : WW) + 1;
  localparam int RCMP_W = ((ROW_W > HW) ? ROW_W : HW) + 1;

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_TGL      = 5'b00010,
    S_ADV_LOAD = 5'b00100,
    S_ADV_CALC = 5'b01000,
    S_ONE      = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [REG_W-1:0]      width_r, height_r;
  logic [WW-1:0]         eff_w;
  logic [HW-1:0]         eff_h;
  logic [MAX_WIDTH-1:0]  mask;
  logic [MAX_HEIGHT-1:0] vld_r;

  logic                  rd_vld_r;
  logic [MAX_WIDTH-1:0]  rd_data, rd_raw, rd_masked;
  logic                  ram_re, ram_we;
  logic [AW-1:0]         ram_raddr, ram_waddr;
  logic [MAX_WIDTH-1:0]  ram_wdata;

  logic [HW-1:0]         r_r, r_plus1;
  logic [HW:0]           r_plus2;
  logic                  changed_r, last_row, row_changed;
  logic [MAX_WIDTH-1:0]  above_r, cur_r, down, nw;

  logic [COL_W-1:0]      tgl_col_r;
  logic [ROW_W-1:0]      tgl_row_r;
  logic                  pend_applied_r;
  logic [MAX_WIDTH-1:0]  tgl_new;
  logic                  tgl_ok;

  logic                  accept, slot_free, adv_step, tgl_step, one_step;
  logic                  out_load;
  logic [IDX_W-1:0]      ld_idx;
  logic [MAX_WIDTH-1:0]  ld_bits;
  logic                  ld_applied, ld_stable, ld_last;

  logic                  out_vld_r;
  logic [IDX_W-1:0]      out_idx_r;
  logic [MAX_WIDTH-1:0]  out_bits_r;
  logic                  out_applied_r, out_stable_r, out_last_r;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= REG_RESET;
      height_r <= REG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_GRID_WIDTH:  width_r  <= cfg_wdata;
        CFG_GRID_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // clamp to 1..max
  always_comb begin
    if (width_r == '0) begin
      eff_w = WW'(1);
    end else if ({1'b0, width_r} > (REG_W+1)'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(width_r);
    end
    if (height_r == '0) begin
      eff_h = HW'(1);
    end else if ({1'b0, height_r} > (REG_W+1)'(MAX_HEIGHT)) begin
      eff_h = HW'(MAX_HEIGHT);
    end else begin
      eff_h = HW'(height_r);
    end
  end

  for (genvar k = 0; k < MAX_WIDTH; k++) begin : g_mask
    assign mask[k] = (WW+1)'(k) < (WW+1)'(eff_w);
  end

  // ---------------------------------------------------------------- datapath
  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign slot_free = !out_vld_r || !out_stall;
  assign adv_step  = (state_r == S_ADV_CALC) && slot_free;
  assign tgl_step  = (state_r == S_TGL) && slot_free;
  assign one_step  = (state_r == S_ONE) && slot_free;

  assign tgl_ok = (CMP_W'(in_col) < CMP_W'(eff_w)) && (RCMP_W'(in_row) < RCMP_W'(eff_h));

  assign rd_raw    = rd_vld_r ? rd_data : '0;
  assign rd_masked = rd_raw & mask;

  assign r_plus1  = r_r + 1'b1;
  assign r_plus2  = (HW+1)'(r_r) + (HW+1)'(2);
  assign last_row = (r_plus1 == eff_h);
  assign down     = (r_plus1 < eff_h) ? rd_masked : '0;

  lge_row_rule #(
    .WIDTH (MAX_WIDTH)
  ) u_rule (
    .above (above_r),
    .cur   (cur_r),
    .below (down),
    .mask  (mask),
    .nxt   (nw)
  );

  assign row_changed = (nw != cur_r);
  assign tgl_new     = rd_raw ^ (MAX_WIDTH'(1) << tgl_col_r);

  // RAM port control: reads run two rows ahead of the write-back
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = '0;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = nw;
    unique case (state_r)
      S_IDLE: begin
        if (accept && (in_mode == MODE_ADVANCE)) begin
          ram_re = 1'b1;
        end else if (accept && (in_mode == MODE_TOGGLE) && tgl_ok) begin
          ram_re    = 1'b1;
          ram_raddr = in_row[AW-1:0];
        end
      end
      S_ADV_LOAD: begin
        if (eff_h > HW'(1)) begin
          ram_re    = 1'b1;
          ram_raddr = AW'(1);
        end
      end
      S_ADV_CALC: begin
        if (adv_step) begin
          ram_we    = 1'b1;
          ram_waddr = r_r[AW-1:0];
          if (r_plus2 < (HW+1)'(eff_h)) begin
            ram_re    = 1'b1;
            ram_raddr = r_plus2[AW-1:0];
          end
        end
      end
      S_TGL: begin
        if (tgl_step) begin
          ram_we    = 1'b1;
          ram_waddr = tgl_row_r[AW-1:0];
          ram_wdata = tgl_new;
        end
      end
      S_ONE: ;
      default: ;
    endcase
  end

  lge_ram #(
    .WIDTH (MAX_WIDTH),
    .DEPTH (MAX_HEIGHT)
  ) u_grid_ram (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .re      (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (rd_data)
  );

  // row valid flops: an unwritten row reads as dead
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (accept && (in_mode == MODE_CLEAR)) begin
      vld_r <= '0;
    end else if (tgl_step) begin
      vld_r[tgl_row_r[AW-1:0]] <= 1'b1;
    end else if (adv_step) begin
      vld_r[r_r[AW-1:0]] <= 1'b1;
      if (last_row) begin
        // drop rows beyond the in-use height
        for (int i = 0; i < MAX_HEIGHT; i++) begin
          if ((HW+1)'(i) >= (HW+1)'(eff_h)) begin
            vld_r[i] <= 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else if (ram_re) begin
      rd_vld_r <= vld_r[ram_raddr];
    end
  end

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_mode == MODE_ADVANCE) begin
            state_nxt = S_ADV_LOAD;
          end else if ((in_mode == MODE_TOGGLE) && tgl_ok) begin
            state_nxt = S_TGL;
          end else begin
            state_nxt = S_ONE;
          end
        end
      end
      S_TGL:      if (tgl_step) state_nxt = S_IDLE;
      S_ADV_LOAD: state_nxt = S_ADV_CALC;
      S_ADV_CALC: if (adv_step && last_row) state_nxt = S_IDLE;
      S_ONE:      if (one_step) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      r_r       <= '0;
      changed_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept && (in_mode == MODE_ADVANCE)) begin
        r_r       <= '0;
        changed_r <= 1'b0;
      end else if (adv_step) begin
        r_r       <= r_plus1;
        changed_r <= changed_r | row_changed;
      end
    end
  end

  // row window: above holds the old row, cur the old current row
  always_ff @(posedge clk) begin
    if (accept && (in_mode == MODE_ADVANCE)) begin
      above_r <= '0;
    end else if (state_r == S_ADV_LOAD) begin
      cur_r <= rd_masked;
    end else if (adv_step) begin
      above_r <= cur_r;
      cur_r   <= down;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tgl_col_r      <= in_col;
      tgl_row_r      <= (in_mode == MODE_TOGGLE) ? in_row : '0;
      pend_applied_r <= (in_mode == MODE_CLEAR);
    end
  end

  // ---------------------------------------------------------------- output
  assign out_load = adv_step || tgl_step || one_step;

  always_comb begin
    ld_idx     = tgl_row_r;
    ld_bits    = '0;
    ld_applied = pend_applied_r;
    ld_stable  = 1'b0;
    ld_last    = 1'b1;
    if (state_r == S_ADV_CALC) begin
      ld_idx     = IDX_W'(r_r);
      ld_bits    = nw;
      ld_applied = 1'b1;
      ld_stable  = last_row && !(changed_r || row_changed);
      ld_last    = last_row;
    end else if (state_r == S_TGL) begin
      ld_bits    = tgl_new & mask;
      ld_applied = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_load) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_idx_r     <= ld_idx;
      out_bits_r    <= ld_bits;
      out_applied_r <= ld_applied;
      out_stable_r  <= ld_stable;
      out_last_r    <= ld_last;
    end
  end

  assign out_valid     = out_vld_r;
  assign out_row_index = out_idx_r;
  assign out_row_bits  = out_bits_r;
  assign out_applied   = out_applied_r;
  assign out_stable    = out_stable_r;
  assign out_last      = out_last_r;

  // ---------------------------------------------------------------- checks
  a_write_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> out_load)
    else $error("grid row written without a result being loaded");

  a_no_write_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> !ram_we)
    else $error("grid row written in the cycle an input transfer is taken");

  a_stable_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_stable_r |-> out_last_r)
    else $error("stable flag on a result that is not the last");

endmodule

@@ rtl/core/lge_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone, no package dependency.
module lge_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             re,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (re) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/core/lge_row_rule.sv @@
// B3/S23 rule for one row: next row from the rows above, current and below.
// Uses lge_pkg for the neighbor count width and rule counts.
module lge_row_rule
  import lge_pkg::*;
#(
  parameter int WIDTH = MAX_WIDTH_DEF
) (
  input  logic [WIDTH-1:0] above,
  input  logic [WIDTH-1:0] cur,
  input  logic [WIDTH-1:0] below,
  input  logic [WIDTH-1:0] mask,
  output logic [WIDTH-1:0] nxt
);

  // pad one dead cell on each side so edge columns see dead neighbors
  logic [WIDTH+1:0] up_p, cur_p, dn_p;

  assign up_p  = {1'b0, above, 1'b0};
  assign cur_p = {1'b0, cur,   1'b0};
  assign dn_p  = {1'b0, below, 1'b0};

  for (genvar k = 0; k < WIDTH; k++) begin : g_col
    logic [NBR_CNT_W-1:0] cnt;
    assign cnt = NBR_CNT_W'(up_p[k]) + NBR_CNT_W'(up_p[k+1]) + NBR_CNT_W'(up_p[k+2])
               + NBR_CNT_W'(cur_p[k]) + NBR_CNT_W'(cur_p[k+2])
               + NBR_CNT_W'(dn_p[k]) + NBR_CNT_W'(dn_p[k+1]) + NBR_CNT_W'(dn_p[k+2]);
    assign nxt[k] = mask[k] & ((cnt == BIRTH_CNT) || ((cnt == SURVIVE_CNT) && cur[k]));
  end

endmodule
